// ----- rtl/b2da_pkg.sv -----
// Shared constants for the binary to decimal ASCII converter.
`default_nettype none

package b2da_pkg;

  localparam int VALUE_W   = 31;
  localparam int CHAR_W    = 6;
  localparam int DIGIT_W   = 4;
  localparam int BIT_CNT_W = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;

endpackage

`default_nettype wire

// ----- rtl/binary_to_decimal_ascii.sv -----
// Top level: bit-serial double-dabble binary to ASCII decimal converter.
// Sequence: input transaction, VALUE_W (31) shift-and-correct steps, then one step
//   per BCD digit position (MAX_DIGITS): leading zeros are dropped, others emitted.
// A new number is taken only in idle, once the last digit of the previous one is out;
//   the 31-step serial dabble loop and one digit per cycle (while out is free) set this.
// Reset: synchronous active-low rst_n returns to idle and clears the output valid.
`default_nettype none

module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [b2da_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]  out_digit_char,
  output logic                         out_last
);

  import b2da_pkg::*;

  localparam int BCD_W = DIGIT_W * MAX_DIGITS;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_t;

  state_t                 state_r,   state_nxt;
  logic [VALUE_W-1:0]     value_r,   value_nxt;    // binary shift register, MSB out
  logic [BCD_W-1:0]       bcd_r,     bcd_nxt;      // BCD digits, most significant on top
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;  // remaining dabble steps - 1
  logic [CNT_W-1:0]       dig_cnt_r, dig_cnt_nxt;  // digit positions left to scan
  logic                   started_r, started_nxt;  // first non-zero digit seen
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r,  out_char_nxt;
  logic                   out_last_r,  out_last_nxt;

  logic [BCD_W-1:0]       bcd_adj;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   out_free;

  // Add-3 correction on every digit lane before the shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= DABBLE_MIN) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    value_nxt     = value_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          value_nxt   = in_value;
          bcd_nxt     = '0;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_W - 1);
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        // Digits past the top lane fall off, keeping value mod 10^MAX_DIGITS.
        bcd_nxt   = {bcd_adj[BCD_W-2:0], value_r[VALUE_W-1]};
        value_nxt = {value_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        if (bit_cnt_r == '0) begin
          dig_cnt_nxt = CNT_FULL;
          started_nxt = 1'b0;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          bcd_nxt     = bcd_r << DIGIT_W;
          dig_cnt_nxt = dig_cnt_r - CNT_ONE;
          if (started_r || top_digit != '0 || dig_cnt_r == CNT_ONE) begin
            // Emit this digit; the lowest one always goes out, so zero gives "0".
            started_nxt   = 1'b1;
            out_valid_nxt = 1'b1;
            out_char_nxt  = ASCII_ZERO + CHAR_W'(top_digit);
            out_last_nxt  = (dig_cnt_r == CNT_ONE);
            if (dig_cnt_r == CNT_ONE) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    value_r    <= value_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire
